// ===== sv/cfsd_pkg.sv =====
package cfsd_pkg;

  typedef enum logic [3:0] {
    SEC_HEADER     = 4'd0,
    SEC_POOLCOUNT  = 4'd1,
    SEC_TAG        = 4'd2,
    SEC_POOLBODY   = 4'd3,
    SEC_CLASSHDR   = 4'd4,
    SEC_IFCOUNT    = 4'd5,
    SEC_IFACE      = 4'd6,
    SEC_FIELDCOUNT = 4'd7,
    SEC_FIELDHDR   = 4'd8,
    SEC_METHCOUNT  = 4'd9,
    SEC_METHHDR    = 4'd10,
    SEC_ATTRHDR    = 4'd11,
    SEC_ATTRBODY   = 4'd12,
    SEC_AFTER      = 4'd13
  } sec_t;

  // last byte offset of each fixed-size unit, and where a count or length starts in it
  localparam logic [31:0] HEADER_LAST   = 32'd7;
  localparam logic [31:0] COUNT_LAST    = 32'd1;
  localparam logic [31:0] CLASSHDR_LAST = 32'd5;
  localparam logic [31:0] MEMBER_CNT_AT = 32'd6;
  localparam logic [31:0] MEMBER_LAST   = 32'd7;
  localparam logic [31:0] ATTR_LEN_AT   = 32'd2;
  localparam logic [31:0] ATTR_LAST     = 32'd5;
  localparam logic [31:0] UTF8_LEN_LAST = 32'd2;

  localparam logic [3:0] BODY_LEN_REF    = 4'd2;
  localparam logic [3:0] BODY_LEN_HANDLE = 4'd3;
  localparam logic [3:0] BODY_LEN_WORD   = 4'd4;
  localparam logic [3:0] BODY_LEN_WIDE   = 4'd8;

  localparam logic [7:0] TAG_UTF8   = 8'd1;
  localparam logic [7:0] TAG_LONG   = 8'd5;
  localparam logic [7:0] TAG_DOUBLE = 8'd6;

  typedef struct packed {
    sec_t        section;
    logic [15:0] pool_slot;
    logic [15:0] pool_total;
    logic [31:0] byte_offset;
    logic [31:0] bytes_left;
    logic [7:0]  entry_tag;
    logic [15:0] list_left;
    logic [15:0] list_position;
    logic [15:0] attrs_left;
    logic [15:0] attr_position;
    logic        doing_fields;
    logic        error_seen;
    logic [31:0] value_gather;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    section:       SEC_HEADER,
    pool_slot:     16'd1,
    pool_total:    16'd0,
    byte_offset:   32'd0,
    bytes_left:    32'd0,
    entry_tag:     8'd0,
    list_left:     16'd0,
    list_position: 16'd0,
    attrs_left:    16'd0,
    attr_position: 16'd0,
    doing_fields:  1'b0,
    error_seen:    1'b0,
    value_gather:  32'd0
  };

  typedef struct packed {
    logic [7:0]  byte_out;
    sec_t        section;
    logic [15:0] item_index;
    logic [15:0] attribute_index;
    logic [31:0] unit_offset;
    logic [7:0]  pool_tag;
    logic        unit_end;
    logic        parse_done;
    logic        format_error;
  } label_t;

  typedef struct packed {
    logic       known;
    logic [3:0] len;
  } tag_info_t;

  // body length after the tag byte; UTF-8 carries its own length
  function automatic tag_info_t tag_info(input logic [7:0] t);
    tag_info_t r;
    r.known = 1'b1;
    r.len   = 4'd0;
    unique case (t)
      8'd7, 8'd8, 8'd16:                            r.len = BODY_LEN_REF;
      8'd15:                                        r.len = BODY_LEN_HANDLE;
      8'd3, 8'd4, 8'd9, 8'd10, 8'd11, 8'd12, 8'd18: r.len = BODY_LEN_WORD;
      8'd5, 8'd6:                                   r.len = BODY_LEN_WIDE;
      8'd1:                                         r.len = 4'd0;
      default:                                      r.known = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/class_file_structure_deframer.sv =====
// A byte's label is registered and shows on the output in the cycle after the byte is accepted.
// Throughput: one byte per cycle; in_tready drops only while a label waits
// on out_tready, and a new byte is taken in the same cycle the label leaves.
// Reset (rst_n low, synchronous) returns the parser to the file header and
// empties the output register; in_tuser on a byte does the same for the parser.
module class_file_structure_deframer import cfsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [7:0] byte_out, [23:8] item_index,
                                  // [39:24] attribute_index, [71:40] unit_offset,
                                  // [79:72] pool_tag
  output logic        out_tlast,  // unit_end
  output logic [7:0]  out_tuser   // [3:0] section, [4] parse_done, [5] format_error
);

  parse_state_t st_r;
  parse_state_t st_nxt;
  label_t       label_nxt;
  label_t       label_r;
  logic         out_valid_r;
  logic         in_fire;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  cfsd_step u_step (
    .st        (st_r),
    .data_byte (in_tdata),
    .restart   (in_tuser),
    .st_nxt    (st_nxt),
    .label     (label_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) st_r <= st_nxt;
      if (in_fire)         out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) label_r <= label_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {label_r.pool_tag, label_r.unit_offset, label_r.attribute_index,
                       label_r.item_index, label_r.byte_out};
  assign out_tlast  = label_r.unit_end;
  assign out_tuser  = {2'b00, label_r.format_error, label_r.parse_done, label_r.section};

`ifndef NO_ASSERTIONS
  // error flag holds until a restart request
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.error_seen && !(in_fire && in_tuser) |=> st_r.error_seen)
    else $error("format error flag dropped without restart");

  // an error always leaves the parser in the trailing section
  a_error_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && label_r.format_error |-> label_r.parse_done)
    else $error("format error without parse done");

  a_after_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && label_r.section == SEC_AFTER |->
      label_r.unit_offset == 32'd0 && !label_r.unit_end)
    else $error("trailing byte carries offset or unit end");

  a_slot_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pool_slot != 16'd0)
    else $error("pool slot reached zero");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output register");
`endif

endmodule

// ===== sv/cfsd_step.sv =====
module cfsd_step import cfsd_pkg::*; (
  input  parse_state_t st,
  input  logic [7:0]   data_byte,
  input  logic         restart,
  output parse_state_t st_nxt,
  output label_t       label
);

  function automatic parse_state_t go_to(input parse_state_t s, input sec_t sec);
    parse_state_t r;
    r = s;
    r.section      = sec;
    r.byte_offset  = '0;
    r.value_gather = '0;
    return r;
  endfunction

  function automatic parse_state_t finish_member(input parse_state_t s);
    parse_state_t r;
    r = s;
    r.list_left     = s.list_left - 16'd1;
    r.list_position = s.list_position + 16'd1;
    if (r.list_left != 16'd0) begin
      r = go_to(r, s.doing_fields ? SEC_FIELDHDR : SEC_METHHDR);
    end else if (s.doing_fields) begin
      r.doing_fields = 1'b0;
      r = go_to(r, SEC_METHCOUNT);
    end else begin
      r = go_to(r, SEC_AFTER);
    end
    return r;
  endfunction

  function automatic parse_state_t finish_attr(input parse_state_t s);
    parse_state_t r;
    r = s;
    r.attrs_left    = s.attrs_left - 16'd1;
    r.attr_position = s.attr_position + 16'd1;
    if (r.attrs_left != 16'd0) r = go_to(r, SEC_ATTRHDR);
    else                       r = finish_member(r);
    return r;
  endfunction

  parse_state_t cur;
  parse_state_t n;
  tag_info_t    info;
  logic [31:0]  gath;
  logic [31:0]  off;
  logic [16:0]  next_slot;
  sec_t         sec_o;
  logic [15:0]  item;
  logic [15:0]  attr;
  logic [7:0]   tag;
  logic         fin;

  always_comb begin
    cur       = restart ? STATE_RESET : st;
    n         = cur;
    sec_o     = cur.section;
    off       = cur.byte_offset;
    item      = '0;
    attr      = '0;
    tag       = '0;
    fin       = 1'b0;
    info      = tag_info(data_byte);
    gath      = {cur.value_gather[23:0], data_byte};
    next_slot = {1'b0, cur.pool_slot} +
                (((cur.entry_tag == TAG_LONG) || (cur.entry_tag == TAG_DOUBLE)) ?
                 17'd2 : 17'd1);

    unique case (cur.section)
      SEC_HEADER: begin
        if (off >= HEADER_LAST) begin
          fin = 1'b1;
          n = go_to(n, SEC_POOLCOUNT);
        end else n.byte_offset = off + 32'd1;
      end
      SEC_POOLCOUNT: begin
        n.value_gather = gath;
        if (off >= COUNT_LAST) begin
          fin = 1'b1;
          n.pool_total = gath[15:0];
          n.pool_slot  = 16'd1;
          n = go_to(n, (gath[15:0] <= 16'd1) ? SEC_CLASSHDR : SEC_TAG);
        end else n.byte_offset = off + 32'd1;
      end
      SEC_TAG: begin
        item        = cur.pool_slot;
        tag         = data_byte;
        n.entry_tag = data_byte;
        if (!info.known) begin
          fin = 1'b1;
          n.error_seen = 1'b1;
          n = go_to(n, SEC_AFTER);
        end else begin
          n.bytes_left   = {28'd0, info.len};
          n.value_gather = '0;
          n.section      = SEC_POOLBODY;
          n.byte_offset  = 32'd1;
        end
      end
      SEC_POOLBODY: begin
        item = cur.pool_slot;
        tag  = cur.entry_tag;
        // UTF-8: two length bytes first, then the counted body
        if (cur.entry_tag == TAG_UTF8 && off <= UTF8_LEN_LAST) begin
          n.value_gather = gath;
          if (off >= UTF8_LEN_LAST) begin
            n.bytes_left = {16'd0, gath[15:0]};
            if (gath[15:0] == 16'd0) fin = 1'b1;
          end
        end else if (cur.bytes_left <= 32'd1) begin
          fin = 1'b1;
        end else begin
          n.bytes_left = cur.bytes_left - 32'd1;
        end
        if (fin) begin
          if (next_slot >= {1'b0, cur.pool_total}) begin
            n = go_to(n, SEC_CLASSHDR);
          end else begin
            n.pool_slot = next_slot[15:0];
            n = go_to(n, SEC_TAG);
          end
        end else n.byte_offset = off + 32'd1;
      end
      SEC_CLASSHDR: begin
        if (off >= CLASSHDR_LAST) begin
          fin = 1'b1;
          n = go_to(n, SEC_IFCOUNT);
        end else n.byte_offset = off + 32'd1;
      end
      SEC_IFCOUNT, SEC_FIELDCOUNT, SEC_METHCOUNT: begin
        n.value_gather = gath;
        if (off >= COUNT_LAST) begin
          fin = 1'b1;
          n.list_left     = gath[15:0];
          n.list_position = '0;
          if (cur.section == SEC_IFCOUNT) begin
            n = go_to(n, (gath[15:0] != 16'd0) ? SEC_IFACE : SEC_FIELDCOUNT);
          end else if (cur.section == SEC_FIELDCOUNT) begin
            if (gath[15:0] != 16'd0) begin
              n.doing_fields = 1'b1;
              n = go_to(n, SEC_FIELDHDR);
            end else n = go_to(n, SEC_METHCOUNT);
          end else begin
            n.doing_fields = 1'b0;
            n = go_to(n, (gath[15:0] != 16'd0) ? SEC_METHHDR : SEC_AFTER);
          end
        end else n.byte_offset = off + 32'd1;
      end
      SEC_IFACE: begin
        item = cur.list_position;
        if (off >= COUNT_LAST) begin
          fin = 1'b1;
          n.list_left     = cur.list_left - 16'd1;
          n.list_position = cur.list_position + 16'd1;
          n = go_to(n, (n.list_left != 16'd0) ? SEC_IFACE : SEC_FIELDCOUNT);
        end else n.byte_offset = off + 32'd1;
      end
      SEC_FIELDHDR, SEC_METHHDR: begin
        item = cur.list_position;
        if (off >= MEMBER_CNT_AT) n.value_gather = gath;
        if (off >= MEMBER_LAST) begin
          fin = 1'b1;
          n.attrs_left    = gath[15:0];
          n.attr_position = '0;
          if (gath[15:0] == 16'd0) n = finish_member(n);
          else                     n = go_to(n, SEC_ATTRHDR);
        end else n.byte_offset = off + 32'd1;
      end
      SEC_ATTRHDR: begin
        item = cur.list_position;
        attr = cur.attr_position;
        if (off >= ATTR_LEN_AT) n.value_gather = gath;
        if (off >= ATTR_LAST) begin
          fin = 1'b1;
          if (gath == 32'd0) begin
            n = finish_attr(n);
          end else begin
            n.bytes_left = gath;
            n = go_to(n, SEC_ATTRBODY);
          end
        end else n.byte_offset = off + 32'd1;
      end
      SEC_ATTRBODY: begin
        item = cur.list_position;
        attr = cur.attr_position;
        if (cur.bytes_left <= 32'd1) begin
          fin = 1'b1;
          n = finish_attr(n);
        end else begin
          n.bytes_left  = cur.bytes_left - 32'd1;
          n.byte_offset = off + 32'd1;
        end
      end
      default: begin
        sec_o     = SEC_AFTER;
        off       = '0;
        n.section = SEC_AFTER;
      end
    endcase

    st_nxt                = n;
    label.byte_out        = data_byte;
    label.section         = sec_o;
    label.item_index      = item;
    label.attribute_index = attr;
    label.unit_offset     = off;
    label.pool_tag        = tag;
    label.unit_end        = fin;
    label.parse_done      = (n.section == SEC_AFTER);
    label.format_error    = n.error_seen;
  end

endmodule

// ===== sim/class_file_structure_deframer_tb.sv =====
module class_file_structure_deframer_tb;
  import cfsd_pkg::*;

  localparam int TARGET_BYTES = 950;
  localparam int CYCLE_LIMIT  = 400000;

  // pool tags besides UTF-8, long and double (those come from the package)
  localparam bit [7:0] TAG_INTEGER      = 8'd3;
  localparam bit [7:0] TAG_FLOAT        = 8'd4;
  localparam bit [7:0] TAG_CLASS        = 8'd7;
  localparam bit [7:0] TAG_STRING       = 8'd8;
  localparam bit [7:0] TAG_FIELDREF     = 8'd9;
  localparam bit [7:0] TAG_METHODREF    = 8'd10;
  localparam bit [7:0] TAG_IFMETHODREF  = 8'd11;
  localparam bit [7:0] TAG_NAMEANDTYPE  = 8'd12;
  localparam bit [7:0] TAG_METHODHANDLE = 8'd15;
  localparam bit [7:0] TAG_METHODTYPE   = 8'd16;
  localparam bit [7:0] TAG_INDY         = 8'd18;

  class label_scoreboard;
    // last byte offset of each fixed-size unit, and where a count or length starts in it
    localparam bit [31:0] HDR_END    = 32'd7;
    localparam bit [31:0] COUNT_END  = 32'd1;
    localparam bit [31:0] CLASS_END  = 32'd5;
    localparam bit [31:0] MEMBER_CNT = 32'd6;
    localparam bit [31:0] MEMBER_END = 32'd7;
    localparam bit [31:0] ALEN_AT    = 32'd2;
    localparam bit [31:0] ATTR_END   = 32'd5;
    localparam bit [31:0] ULEN_END   = 32'd2;

    sec_t      st;
    bit [15:0] slot, total, list_left, list_pos, attrs_left, attr_pos;
    bit [31:0] offs, left, gather;
    bit [7:0]  tag_q;
    bit        fields_mode, err;

    label_t labels_due[$];
    int     checked, mismatches, bad_tags;
    bit     seen[14];

    function new();
      clear();
    endfunction

    function void clear();
      st = SEC_HEADER;
      slot = 16'd1;
      total = '0;
      offs = '0;
      left = '0;
      tag_q = '0;
      list_left = '0;
      list_pos = '0;
      attrs_left = '0;
      attr_pos = '0;
      fields_mode = 1'b0;
      err = 1'b0;
      gather = '0;
    endfunction

    static function int body_len(bit [7:0] t);
      case (t)
        TAG_CLASS, TAG_STRING, TAG_METHODTYPE: return BODY_LEN_REF;
        TAG_METHODHANDLE: return BODY_LEN_HANDLE;
        TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF, TAG_IFMETHODREF,
        TAG_NAMEANDTYPE, TAG_INDY: return BODY_LEN_WORD;
        TAG_LONG, TAG_DOUBLE: return BODY_LEN_WIDE;
        TAG_UTF8: return 0;
        default: return -1;
      endcase
    endfunction

    function void go(sec_t s);
      st = s;
      offs = '0;
      gather = '0;
    endfunction

    function void end_member();
      list_left--;
      list_pos++;
      if (list_left != 0) go(fields_mode ? SEC_FIELDHDR : SEC_METHHDR);
      else if (fields_mode) begin
        fields_mode = 1'b0;
        go(SEC_METHCOUNT);
      end else go(SEC_AFTER);
    endfunction

    function void end_attr();
      attrs_left--;
      attr_pos++;
      if (attrs_left != 0) go(SEC_ATTRHDR);
      else end_member();
    endfunction

    function label_t label_byte(bit [7:0] b, bit rs);
      label_t    r;
      sec_t      s;
      bit [31:0] off;
      bit [31:0] nxt;
      int        len;
      if (rs) clear();
      s = st;
      off = offs;
      r = '0;
      case (s)
        SEC_HEADER: begin
          if (off >= HDR_END) begin
            r.unit_end = 1'b1;
            go(SEC_POOLCOUNT);
          end else offs++;
        end
        SEC_POOLCOUNT: begin
          gather = {gather[23:0], b};
          if (off >= COUNT_END) begin
            r.unit_end = 1'b1;
            total = gather[15:0];
            slot = 16'd1;
            go(total <= 16'd1 ? SEC_CLASSHDR : SEC_TAG);
          end else offs++;
        end
        SEC_TAG: begin
          len = body_len(b);
          r.item_index = slot;
          r.pool_tag = b;
          tag_q = b;
          if (len < 0) begin
            r.unit_end = 1'b1;
            err = 1'b1;
            bad_tags++;
            go(SEC_AFTER);
          end else begin
            left = 32'(len);
            gather = '0;
            st = SEC_POOLBODY;
            offs = 32'd1;
          end
        end
        SEC_POOLBODY: begin
          r.item_index = slot;
          r.pool_tag = tag_q;
          if (tag_q == TAG_UTF8 && off <= ULEN_END) begin
            gather = {gather[23:0], b};
            if (off >= ULEN_END) begin
              left = {16'd0, gather[15:0]};
              if (left == 0) r.unit_end = 1'b1;
            end
          end else if (left <= 1) r.unit_end = 1'b1;
          else left--;
          if (r.unit_end) begin
            nxt = slot + ((tag_q == TAG_LONG || tag_q == TAG_DOUBLE) ? 32'd2 : 32'd1);
            if (nxt >= total) go(SEC_CLASSHDR);
            else begin
              slot = nxt[15:0];
              go(SEC_TAG);
            end
          end else offs++;
        end
        SEC_CLASSHDR: begin
          if (off >= CLASS_END) begin
            r.unit_end = 1'b1;
            go(SEC_IFCOUNT);
          end else offs++;
        end
        SEC_IFCOUNT, SEC_FIELDCOUNT, SEC_METHCOUNT: begin
          gather = {gather[23:0], b};
          if (off >= COUNT_END) begin
            r.unit_end = 1'b1;
            list_left = gather[15:0];
            list_pos = '0;
            if (s == SEC_IFCOUNT) go(list_left != 0 ? SEC_IFACE : SEC_FIELDCOUNT);
            else if (s == SEC_FIELDCOUNT) begin
              if (list_left != 0) begin
                fields_mode = 1'b1;
                go(SEC_FIELDHDR);
              end else go(SEC_METHCOUNT);
            end else begin
              fields_mode = 1'b0;
              go(list_left != 0 ? SEC_METHHDR : SEC_AFTER);
            end
          end else offs++;
        end
        SEC_IFACE: begin
          r.item_index = list_pos;
          if (off >= COUNT_END) begin
            r.unit_end = 1'b1;
            list_left--;
            list_pos++;
            go(list_left != 0 ? SEC_IFACE : SEC_FIELDCOUNT);
          end else offs++;
        end
        SEC_FIELDHDR, SEC_METHHDR: begin
          r.item_index = list_pos;
          if (off >= MEMBER_CNT) gather = {gather[23:0], b};
          if (off >= MEMBER_END) begin
            r.unit_end = 1'b1;
            attrs_left = gather[15:0];
            attr_pos = '0;
            if (attrs_left == 0) end_member();
            else go(SEC_ATTRHDR);
          end else offs++;
        end
        SEC_ATTRHDR: begin
          r.item_index = list_pos;
          r.attribute_index = attr_pos;
          if (off >= ALEN_AT) gather = {gather[23:0], b};
          if (off >= ATTR_END) begin
            r.unit_end = 1'b1;
            if (gather == 0) end_attr();
            else begin
              left = gather;
              go(SEC_ATTRBODY);
            end
          end else offs++;
        end
        SEC_ATTRBODY: begin
          r.item_index = list_pos;
          r.attribute_index = attr_pos;
          if (left <= 1) begin
            r.unit_end = 1'b1;
            end_attr();
          end else begin
            left--;
            offs++;
          end
        end
        default: begin
          s = SEC_AFTER;
          off = '0;
          st = SEC_AFTER;
        end
      endcase
      r.byte_out = b;
      r.section = s;
      r.unit_offset = off;
      r.parse_done = (st == SEC_AFTER);
      r.format_error = err;
      return r;
    endfunction

    function void take_byte(bit [7:0] b, bit rs);
      label_t r;
      r = label_byte(b, rs);
      seen[int'(r.section)] = 1'b1;
      labels_due.push_back(r);
    endfunction

    function string show(label_t l);
      return $sformatf("sec %0d item %0d attr %0d off %0d tag %0h end %0b done %0b err %0b byte %0h",
                       l.section, l.item_index, l.attribute_index, l.unit_offset, l.pool_tag,
                       l.unit_end, l.parse_done, l.format_error, l.byte_out);
    endfunction

    function void check_label(label_t got);
      label_t want;
      string  bad;
      if (labels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected label: %s", show(got));
        return;
      end
      want = labels_due.pop_front();
      checked++;
      bad = "";
      if (got.byte_out !== want.byte_out) bad = {bad, " byte_out"};
      if (got.section !== want.section) bad = {bad, " section"};
      if (got.item_index !== want.item_index) bad = {bad, " item_index"};
      if (got.attribute_index !== want.attribute_index) bad = {bad, " attribute_index"};
      if (got.unit_offset !== want.unit_offset) bad = {bad, " unit_offset"};
      if (got.pool_tag !== want.pool_tag) bad = {bad, " pool_tag"};
      if (got.unit_end !== want.unit_end) bad = {bad, " unit_end"};
      if (got.parse_done !== want.parse_done) bad = {bad, " parse_done"};
      if (got.format_error !== want.format_error) bad = {bad, " format_error"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= 10)
          $display("label %0d mismatch (%s ):\n  expected %s\n  actual   %s",
                   checked, bad, show(want), show(got));
      end
    endfunction

    function int sections_reached();
      int n;
      n = 0;
      foreach (seen[i]) if (seen[i]) n++;
      return n;
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] data_byte
  logic        in_tuser = 1'b0; // [0] restart
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;       // [7:0] byte_out, [23:8] item_index,
                                // [39:24] attribute_index, [71:40] unit_offset,
                                // [79:72] pool_tag
  logic        out_tlast;       // unit_end
  logic [7:0]  out_tuser;       // [3:0] section, [4] parse_done, [5] format_error

  class_file_structure_deframer dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  label_scoreboard sb;
  int  sent, files, cycles;
  int  gap_pct, stall_pct;
  bit  quiet;
  bit [7:0] file_bytes[$];
  int  cut_marks[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d labels still due", cycles, sb.labels_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin : label_mon
    label_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.byte_out = out_tdata[7:0];
      got.section = sec_t'(out_tuser[3:0]);
      got.item_index = out_tdata[23:8];
      got.attribute_index = out_tdata[39:24];
      got.unit_offset = out_tdata[71:40];
      got.pool_tag = out_tdata[79:72];
      got.unit_end = out_tlast;
      got.parse_done = out_tuser[4];
      got.format_error = out_tuser[5];
      sb.check_label(got);
    end
  end

  // receiver backpressure
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(99, 0) < stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(13, 1)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_byte(input bit [7:0] b, input bit rs);
    if (!quiet && $urandom_range(99, 0) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(13, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= rs;
    do @(posedge clk); while (!in_tready);
    sb.take_byte(b, rs);
    sent++;
  endtask

  function automatic void add_random(int n);
    repeat (n) file_bytes.push_back(8'($urandom));
  endfunction

  // counts and lengths are big endian; note where they sit for later corruption
  function automatic void add_count(bit [15:0] v);
    cut_marks.push_back(file_bytes.size());
    file_bytes.push_back(v[15:8]);
    file_bytes.push_back(v[7:0]);
  endfunction

  function automatic bit [15:0] small_count(int hi);
    return ($urandom_range(2, 0) == 0) ? 16'd0 : 16'($urandom_range(hi, 1));
  endfunction

  function automatic bit [7:0] pick_tag();
    case ($urandom_range(13, 0))
      0: return TAG_UTF8;
      1: return TAG_INTEGER;
      2: return TAG_FLOAT;
      3: return TAG_LONG;
      4: return TAG_DOUBLE;
      5: return TAG_CLASS;
      6: return TAG_STRING;
      7: return TAG_FIELDREF;
      8: return TAG_METHODREF;
      9: return TAG_IFMETHODREF;
      10: return TAG_NAMEANDTYPE;
      11: return TAG_METHODHANDLE;
      12: return TAG_METHODTYPE;
      default: return TAG_INDY;
    endcase
  endfunction

  function automatic void add_members(int n);
    bit [15:0] na;
    bit [15:0] len;
    repeat (n) begin
      add_random(6);
      na = small_count(2);
      add_count(na);
      repeat (int'(na)) begin
        add_random(2);
        len = ($urandom_range(3, 0) == 0) ? 16'd0 : 16'($urandom_range(5, 1));
        add_count(16'd0);
        add_count(len);
        add_random(int'(len));
      end
    end
  endfunction

  function automatic void build_class_file();
    int        n, slot_no;
    bit [7:0]  t;
    bit [15:0] len, cnt;
    file_bytes.delete();
    cut_marks.delete();
    add_random(8);
    n = ($urandom_range(4, 0) == 0) ? $urandom_range(1, 0) : $urandom_range(7, 2);
    add_count(16'(n));
    slot_no = 1;
    while (slot_no < n) begin
      if ($urandom_range(29, 0) == 0) begin
        // bad tag: parser stops, the rest is trailing noise
        do t = 8'($urandom); while (label_scoreboard::body_len(t) >= 0);
        file_bytes.push_back(t);
        add_random($urandom_range(4, 0));
        return;
      end
      t = pick_tag();
      file_bytes.push_back(t);
      if (t == TAG_UTF8) begin
        len = ($urandom_range(3, 0) == 0) ? 16'd0 : 16'($urandom_range(4, 1));
        add_count(len);
        add_random(int'(len));
      end else add_random(label_scoreboard::body_len(t));
      slot_no += (t == TAG_LONG || t == TAG_DOUBLE) ? 2 : 1;
    end
    add_random(6);
    cnt = small_count(3);
    add_count(cnt);
    add_random(2 * int'(cnt));
    cnt = small_count(2);
    add_count(cnt);
    add_members(int'(cnt));
    cnt = small_count(3);
    add_count(cnt);
    add_members(int'(cnt));
    add_random($urandom_range(4, 0));
  endfunction

  // overwrite one count with random bits and cut the file shortly after it
  function automatic void corrupt_file();
    int m, keep;
    m = cut_marks[$urandom_range(cut_marks.size() - 1, 0)];
    file_bytes[m] = 8'($urandom);
    file_bytes[m + 1] = 8'($urandom);
    keep = m + 2 + $urandom_range(30, 0);
    while (file_bytes.size() > keep) void'(file_bytes.pop_back());
  endfunction

  initial begin : stim
    bit [7:0] dir[$];
    int       keep;
    sb = new();
    gap_pct = 20;
    stall_pct = 20;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // from reset, no restart: pool count 2, then tag 0 which is unknown
    dir = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h80, 8'h7F, 8'h00, 8'h02, 8'h00};
    foreach (dir[i]) send_byte(dir[i], 1'b0);
    // restart out of the error state: pool count 1 means empty, then all lists empty
    dir = '{8'hCA, 8'hFE, 8'hBA, 8'hBE, 8'h00, 8'h00, 8'h00, 8'h34, 8'h00, 8'h01,
            8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h00, 8'h00};
    foreach (dir[i]) send_byte(dir[i], i == 0);
    files = 2;

    while (sent < TARGET_BYTES) begin
      quiet = (sent >= TARGET_BYTES * 17 / 20);
      gap_pct = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(30, 5);
      stall_pct = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(30, 5);
      if ($urandom_range(11, 0) == 0) begin
        file_bytes.delete();
        add_random($urandom_range(40, 3));
      end else begin
        build_class_file();
        if ($urandom_range(7, 0) == 0) corrupt_file();
        else if ($urandom_range(9, 0) == 0) begin
          keep = $urandom_range(file_bytes.size(), 1);
          while (file_bytes.size() > keep) void'(file_bytes.pop_back());
        end
      end
      foreach (file_bytes[i]) send_byte(file_bytes[i], i == 0);
      files++;
    end
    in_tvalid <= 1'b0;

    while (sb.labels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Sent %0d class-file streams, %0d bytes; %0d labels checked, %0d mismatches.",
             files, sent, sb.checked, sb.mismatches);
    $display("Parser reached %0d of 14 sections; %0d streams stopped on a bad pool tag.",
             sb.sections_reached(), sb.bad_tags);
    if (sb.mismatches == 0 && sb.labels_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
